>>> hw/rtl/msa_pkg.sv
// Shared types and constants for the max-distance seat allocator.
// Depends on nothing; imported by the controller, datapath and top level.
package msa_pkg;

   // Row geometry
   localparam int MAX_SEATS = 1024;
   localparam int SEAT_W    = 10;
   localparam int COUNT_W   = 11;
   localparam int WORD_W    = 32;
   localparam int BIT_W     = $clog2(WORD_W);
   localparam int NUM_WORDS = MAX_SEATS / WORD_W;
   localparam int ADDR_W    = $clog2(NUM_WORDS);
   localparam int NW_W      = ADDR_W + 1;
   localparam int LEVELS    = $clog2(WORD_W);
   localparam int HALF_W    = BIT_W - 1;

   // Result status codes
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_FULL   = 2'd1;
   localparam logic [1:0] STATUS_BADVAC = 2'd2;

   // Operation codes
   localparam logic KIND_ASSIGN = 1'b0;
   localparam logic KIND_VACATE = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [SEAT_W-1:0] seat;
   } req_type;

   typedef struct packed {
      logic [SEAT_W-1:0] chosen_seat;
      logic [1:0]        status;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_FINISH,
      S_VREAD,
      S_COMMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic start;
      logic scan_rd;
      logic finish;
      logic vac_rd;
      logic commit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic kind;
      logic scan_last;
      logic pipe_busy;
      logic out_free;
   } stat_type;

endpackage

>>> hw/rtl/msa_ctrl.sv
// Seat allocator sequencer: assigns pass scan, drain, finish and commit;
// vacates pass read and commit. Depends on msa_pkg; drives msa_datapath.
module msa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  msa_pkg::stat_type stat,
   output msa_pkg::cmd_type  cmd
);
   import msa_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.kind == KIND_VACATE) begin
               state_in = S_VREAD;
            end else begin
               cmd.scan_rd = 1'b1;
               if (stat.scan_last) begin
                  state_in = S_DRAIN;
               end
            end
         end
         S_DRAIN: begin
            if (!stat.pipe_busy) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_COMMIT;
         end
         S_VREAD: begin
            cmd.vac_rd = 1'b1;
            state_in   = S_COMMIT;
         end
         S_COMMIT: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

>>> hw/rtl/msa_datapath.sv
// Datapath of the seat allocator: occupancy memory, gap-scan pipeline,
// final seat choice, read-modify-write and response register. Uses msa_pkg.
module msa_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  msa_pkg::cmd_type            cmd,
   output msa_pkg::stat_type           stat,
   input  msa_pkg::req_type            req_data,
   input  logic                        csr_we,
   input  logic [msa_pkg::COUNT_W-1:0] csr_data,
   output logic                        rsp_valid,
   output msa_pkg::rsp_type            rsp_data,
   input  logic                        rsp_stall
);
   import msa_pkg::*;

   // Occupancy memory, one row valid bit per word
   logic [WORD_W-1:0]    mem [NUM_WORDS];
   logic [NUM_WORDS-1:0] row_valid_ff;
   logic [WORD_W-1:0]    rd_data_ff;
   logic                 rd_row_ok_ff;
   logic                 rd_en;
   logic [ADDR_W-1:0]    rd_addr;
   logic                 wr_en;
   logic [WORD_W-1:0]    wr_data;
   logic [ADDR_W-1:0]    wr_addr;

   // Configuration and item
   logic [COUNT_W-1:0] seats_ff;
   logic [COUNT_W-1:0] n_eff;
   logic [NW_W-1:0]    n_words;
   logic               kind_ff;
   logic [SEAT_W-1:0]  seat_ff;

   // Scan address
   logic [ADDR_W-1:0] scan_addr_ff;

   // Read stage
   logic              s0_v_ff;
   logic [ADDR_W-1:0] s0_word_ff;
   logic [WORD_W-1:0] s0_masked;

   // Stage A: per-bit gap to the previous set bit in the same word
   logic              a_has   [WORD_W];
   logic [BIT_W-1:0]  a_lp    [WORD_W];
   logic [BIT_W-1:0]  a_len   [WORD_W];
   logic [BIT_W:0]    a_sum   [WORD_W];
   logic [BIT_W-1:0]  a_first;
   logic [BIT_W-1:0]  a_last;
   logic              sa_v_ff;
   logic [ADDR_W-1:0] sa_word_ff;
   logic [WORD_W-1:0] sa_cand_ff;
   logic [HALF_W-1:0] sa_d_ff   [WORD_W];
   logic [BIT_W-1:0]  sa_mid_ff [WORD_W];
   logic [BIT_W-1:0]  sa_first_ff;
   logic [BIT_W-1:0]  sa_last_ff;
   logic              sa_any_ff;

   // Stage B: best local gap, earliest wins ties
   logic              t_v [LEVELS+1][WORD_W];
   logic [HALF_W-1:0] t_d [LEVELS+1][WORD_W];
   logic [BIT_W-1:0]  t_m [LEVELS+1][WORD_W];
   logic              sb_v_ff;
   logic [ADDR_W-1:0] sb_word_ff;
   logic              sb_cand_ff;
   logic [HALF_W-1:0] sb_d_ff;
   logic [BIT_W-1:0]  sb_mid_ff;
   logic [BIT_W-1:0]  sb_first_ff;
   logic [BIT_W-1:0]  sb_last_ff;
   logic              sb_any_ff;

   // Stage C: running best across words
   logic               prev_v_ff, prev_v_in;
   logic [SEAT_W-1:0]  prev_ff, prev_in;
   logic [COUNT_W-1:0] best_d_ff, best_d_in;
   logic [SEAT_W-1:0]  best_s_ff, best_s_in;
   logic [SEAT_W-1:0]  abs_first;
   logic [COUNT_W-1:0] cross_len;
   logic [COUNT_W-1:0] cross_d;
   logic [COUNT_W-1:0] cross_sum;
   logic [SEAT_W-1:0]  cross_s;
   logic               cross_v;
   logic [COUNT_W-1:0] mid_d;
   logic [SEAT_W-1:0]  mid_s;

   // Final choice
   logic               found_ff, found_in;
   logic [SEAT_W-1:0]  spot_ff, spot_in;
   logic [COUNT_W-1:0] right_d;

   // Commit
   logic [SEAT_W-1:0] target;
   logic [WORD_W-1:0] cur_word;
   logic [WORD_W-1:0] bit_mask;
   logic              vac_ok;
   rsp_type           rsp_in;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   // Clamp the row size into 1..MAX_SEATS
   always_comb begin
      priority if (seats_ff == '0) begin
         n_eff = COUNT_W'(1);
      end else if (seats_ff > COUNT_W'(MAX_SEATS)) begin
         n_eff = COUNT_W'(MAX_SEATS);
      end else begin
         n_eff = seats_ff;
      end
   end
   assign n_words = NW_W'((n_eff + COUNT_W'(WORD_W - 1)) >> BIT_W);

   // Hold configuration and the current item
   always_ff @(posedge clock) begin
      if (reset) begin
         seats_ff <= COUNT_W'(MAX_SEATS);
      end else if (csr_we) begin
         seats_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         kind_ff <= req_data.kind;
         seat_ff <= req_data.seat;
      end
   end

   // Advance the scan address
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_addr_ff <= '0;
      end else if (cmd.start) begin
         scan_addr_ff <= '0;
      end else if (cmd.scan_rd) begin
         scan_addr_ff <= scan_addr_ff + ADDR_W'(1);
      end
   end

   // Select the read address
   always_comb begin
      rd_en   = cmd.scan_rd | cmd.finish | cmd.vac_rd;
      priority if (cmd.scan_rd) begin
         rd_addr = scan_addr_ff;
      end else if (cmd.finish) begin
         rd_addr = spot_in[SEAT_W-1:BIT_W];
      end else begin
         rd_addr = seat_ff[SEAT_W-1:BIT_W];
      end
   end

   // Memory read and write; a row never written reads as all free
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_row_ok_ff <= 1'b0;
      end else begin
         if (rd_en) begin
            rd_row_ok_ff <= row_valid_ff[rd_addr];
         end
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // Track which read belongs to the scan
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else begin
         s0_v_ff <= cmd.scan_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_rd) begin
         s0_word_ff <= scan_addr_ff;
      end
   end

   // Drop seats outside the row
   always_comb begin
      for (int j = 0; j < WORD_W; j++) begin
         s0_masked[j] = rd_row_ok_ff & rd_data_ff[j] &
                        (COUNT_W'({s0_word_ff, BIT_W'(j)}) < n_eff);
      end
   end

   // Stage A: previous set bit for each position, first and last set bits
   always_comb begin
      for (int j = 0; j < WORD_W; j++) begin
         a_has[j] = 1'b0;
         a_lp[j]  = '0;
         for (int k = 0; k < j; k++) begin
            if (s0_masked[k]) begin
               a_has[j] = 1'b1;
               a_lp[j]  = BIT_W'(k);
            end
         end
         a_len[j] = BIT_W'(j) - a_lp[j];
         a_sum[j] = {1'b0, a_lp[j]} + (BIT_W + 1)'(j);
      end
      a_first = '0;
      for (int j = WORD_W - 1; j >= 0; j--) begin
         if (s0_masked[j]) begin
            a_first = BIT_W'(j);
         end
      end
      a_last = '0;
      for (int j = 0; j < WORD_W; j++) begin
         if (s0_masked[j]) begin
            a_last = BIT_W'(j);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_v_ff <= 1'b0;
      end else begin
         sa_v_ff <= s0_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      sa_word_ff  <= s0_word_ff;
      sa_first_ff <= a_first;
      sa_last_ff  <= a_last;
      sa_any_ff   <= |s0_masked;
      for (int j = 0; j < WORD_W; j++) begin
         sa_cand_ff[j] <= s0_masked[j] & a_has[j] & (a_len[j] >= BIT_W'(2));
         sa_d_ff[j]    <= a_len[j][BIT_W-1:1];
         sa_mid_ff[j]  <= a_sum[j][BIT_W:1];
      end
   end

   // Stage B: reduce the word's gaps in a tree, left side wins ties
   always_comb begin
      for (int i = 0; i < WORD_W; i++) begin
         t_v[0][i] = sa_cand_ff[i];
         t_d[0][i] = sa_d_ff[i];
         t_m[0][i] = sa_mid_ff[i];
      end
      for (int l = 1; l <= LEVELS; l++) begin
         for (int i = 0; i < WORD_W; i++) begin
            t_v[l][i] = 1'b0;
            t_d[l][i] = '0;
            t_m[l][i] = '0;
         end
         for (int i = 0; i < (WORD_W >> l); i++) begin
            if (t_v[l-1][2*i+1] &&
                (!t_v[l-1][2*i] || (t_d[l-1][2*i+1] > t_d[l-1][2*i]))) begin
               t_v[l][i] = 1'b1;
               t_d[l][i] = t_d[l-1][2*i+1];
               t_m[l][i] = t_m[l-1][2*i+1];
            end else begin
               t_v[l][i] = t_v[l-1][2*i];
               t_d[l][i] = t_d[l-1][2*i];
               t_m[l][i] = t_m[l-1][2*i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sb_v_ff <= 1'b0;
      end else begin
         sb_v_ff <= sa_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      sb_word_ff  <= sa_word_ff;
      sb_cand_ff  <= t_v[LEVELS][0];
      sb_d_ff     <= t_d[LEVELS][0];
      sb_mid_ff   <= t_m[LEVELS][0];
      sb_first_ff <= sa_first_ff;
      sb_last_ff  <= sa_last_ff;
      sb_any_ff   <= sa_any_ff;
   end

   // Stage C: gap across the word boundary first, then the word's own best
   always_comb begin
      abs_first = {sb_word_ff, sb_first_ff};
      cross_sum = {1'b0, prev_ff} + {1'b0, abs_first};
      cross_len = {1'b0, abs_first} - {1'b0, prev_ff};
      if (!prev_v_ff) begin
         cross_d = {1'b0, abs_first};
         cross_s = '0;
         cross_v = (abs_first != '0);
      end else begin
         cross_d = cross_len >> 1;
         cross_s = cross_sum[COUNT_W-1:1];
         cross_v = (cross_len >= COUNT_W'(2));
      end
      if (cross_v && (cross_d > best_d_ff)) begin
         mid_d = cross_d;
         mid_s = cross_s;
      end else begin
         mid_d = best_d_ff;
         mid_s = best_s_ff;
      end
      prev_v_in = prev_v_ff;
      prev_in   = prev_ff;
      best_d_in = best_d_ff;
      best_s_in = best_s_ff;
      if (cmd.start) begin
         prev_v_in = 1'b0;
         best_d_in = '0;
      end else if (sb_v_ff && sb_any_ff) begin
         prev_v_in = 1'b1;
         prev_in   = {sb_word_ff, sb_last_ff};
         if (sb_cand_ff && (COUNT_W'(sb_d_ff) > mid_d)) begin
            best_d_in = COUNT_W'(sb_d_ff);
            best_s_in = {sb_word_ff, sb_mid_ff};
         end else begin
            best_d_in = mid_d;
            best_s_in = mid_s;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_v_ff <= 1'b0;
         best_d_ff <= '0;
      end else begin
         prev_v_ff <= prev_v_in;
         best_d_ff <= best_d_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff   <= prev_in;
      best_s_ff <= best_s_in;
   end

   // Close with the right edge gap and pick the seat
   always_comb begin
      right_d = n_eff - COUNT_W'(1) - {1'b0, prev_ff};
      priority if (!prev_v_ff) begin
         spot_in  = '0;
         found_in = 1'b1;
      end else if (right_d > best_d_ff) begin
         spot_in  = SEAT_W'(n_eff - COUNT_W'(1));
         found_in = 1'b1;
      end else begin
         spot_in  = best_s_ff;
         found_in = (best_d_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         spot_ff  <= spot_in;
         found_ff <= found_in;
      end
   end

   // Read-modify-write of the target seat and result
   always_comb begin
      target   = (kind_ff == KIND_VACATE) ? seat_ff : spot_ff;
      cur_word = rd_row_ok_ff ? rd_data_ff : '0;
      bit_mask = WORD_W'(1) << target[BIT_W-1:0];
      vac_ok   = ({1'b0, seat_ff} < n_eff) && ((cur_word & bit_mask) != '0);
      wr_addr  = target[SEAT_W-1:BIT_W];
      if (kind_ff == KIND_VACATE) begin
         wr_en              = cmd.commit & vac_ok;
         wr_data            = cur_word & ~bit_mask;
         rsp_in.chosen_seat = seat_ff;
         rsp_in.status      = vac_ok ? STATUS_OK : STATUS_BADVAC;
      end else begin
         wr_en              = cmd.commit & found_ff;
         wr_data            = cur_word | bit_mask;
         rsp_in.chosen_seat = found_ff ? spot_ff : '0;
         rsp_in.status      = found_ff ? STATUS_OK : STATUS_FULL;
      end
   end

   // Output register: load on commit, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Status to the controller
   assign stat.kind      = kind_ff;
   assign stat.scan_last = ({1'b0, scan_addr_ff} + NW_W'(1)) >= n_words;
   assign stat.pipe_busy = s0_v_ff | sa_v_ff | sb_v_ff;
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

endmodule

>>> hw/rtl/max_distance_seat_allocator.sv
// Max-distance seat allocator, top level. Uses msa_pkg, msa_ctrl, msa_datapath.
// Assign: one 32-seat word read per cycle into a three-stage gap pipeline,
// then the seat choice and commit; the next item is taken only after commit.
// Vacate: one word read and write; the next item is taken only after commit.
// A stalled result holds the commit. Reset (synchronous, active high) frees
// every seat through per-word valid bits and sets the row size to 1024.
module max_distance_seat_allocator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  msa_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output msa_pkg::rsp_type            rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [msa_pkg::COUNT_W-1:0] csr_data
);
   import msa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Row size register takes writes at any time
   assign csr_ready = 1'b1;

   msa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   msa_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .csr_we    (csr_valid & csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

`ifndef SYNTH
   // An accepted transaction keeps the input side closed next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted twice in a row");

   // A commit always presents a result in the next cycle
   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("commit did not present a result");

   // A full row reports seat zero
   a_full_seat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == STATUS_FULL)) |-> (rsp_data.chosen_seat == '0))
      else $error("full status with nonzero seat");

   // No commit while the output register still holds an untaken result
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid || !rsp_stall))
      else $error("result overwritten");
`endif

endmodule
